/* rtl/core/mwr_pkg.sv */
// Shared types, constants and helpers for the maze wall rasterizer.
package mwr_pkg;

    // Image and maze limits
    localparam int IMAGE_DIM          = 256;
    localparam int MAX_GRID           = 8;
    localparam int MAX_CELLS_PER_SIDE = 30;

    // Bitmap store geometry
    localparam int BYTES_PER_LINE = (IMAGE_DIM + 7) / 8;
    localparam int STORE_BYTES    = BYTES_PER_LINE * IMAGE_DIM;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int PIX_W          = $clog2(IMAGE_DIM);
    localparam int HBYTE_W        = PIX_W - 3;

    // Field widths fixed by the item layout
    localparam int GRID_W  = 4;
    localparam int CELL_W  = 5;
    localparam int LINE_W  = 8;
    localparam int BIDX_W  = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Pixel counter within one wall segment (0..grid)
    localparam int CNT_W  = $clog2(MAX_GRID + 1);
    // Width of grid*(cells+2) products and the image-size compare
    localparam int SPAN_W = 11;

    // Function codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

    // Status codes
    localparam logic STAT_DONE   = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // Control states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SETUP,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FETCH
    } t_state;

    // Wall segments, also the bit order of the pending-wall mask
    typedef enum logic [1:0] {
        SEG_WEST,
        SEG_NORTH,
        SEG_SOUTH,
        SEG_EAST
    } t_seg;

    typedef struct packed {
        logic [1:0]        func;
        logic [CELL_W-1:0] cell_col;
        logic [CELL_W-1:0] cell_row;
        logic              wall_west;
        logic              wall_north;
        logic              wall_south;
        logic              wall_east;
        logic [LINE_W-1:0] read_line;
        logic [BIDX_W-1:0] read_byte_index;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } t_result;

    // Byte address of (pixel row, byte within row)
    function automatic logic [ADDR_W-1:0] mem_addr(input int line, input int bidx);
        int a;
        a = line * BYTES_PER_LINE + bidx;
        return ADDR_W'(a);
    endfunction

endpackage

/* rtl/core/maze_wall_rasterizer.sv */
// Maze wall rasterizer: 1-bpp bitmap store with clear, draw-cell and read-byte items.
// Draw item: each byte touched, up to 22, goes through a read-modify-write of the store.
// Clear item: the whole store is written to white, one byte written per cycle.
// Throughput: one item at a time; busy stays high until the item's result is issued.
// Reset: the store is swept to white with busy high; config
//   writes are taken at any time. Results are strobed for one cycle and cannot be stalled.
module maze_wall_rasterizer
    import mwr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Registers
    t_state              r_state, n_state;
    t_item               r_item, n_item;
    logic [GRID_W-1:0]   r_grid;
    logic [CELL_W-1:0]   r_cols, r_rows;
    logic [PIX_W-1:0]    r_x, n_x, r_y, n_y;
    logic [3:0]          r_walls, n_walls;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [7:0]          r_mask, n_mask;
    logic [ADDR_W-1:0]   r_sweep, n_sweep;
    logic                r_from_clear, n_from_clear;
    logic [7:0]          r_q;
    logic                r_strobe, n_strobe;
    t_result             r_result, n_result;

    // Memory port controls
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem [STORE_BYTES];

    logic                accept;
    logic                rd_in_range;
    logic [ADDR_W-1:0]   rd_addr;
    logic                sweep_last;

    // Draw setup
    logic [SPAN_W-1:0]   span_w, span_h;
    logic                set_ok, cell_ok, draw_ok;
    logic [3:0]          walls_eff;
    logic [9:0]          x_full, y_full;

    // Segment stepping
    t_seg                seg;
    logic                seg_vert;
    logic                seg_last;
    logic [3:0]          walls_left;
    logic [PIX_W-1:0]    px, py;
    logic [HBYTE_W-1:0]  hbyte;
    logic [15:0]         hmask16;
    logic [ADDR_W-1:0]   op_addr;
    logic [7:0]          op_mask;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign sweep_last  = (r_sweep == ADDR_W'(STORE_BYTES - 1));

    // Read item address and range check
    assign rd_in_range = (int'(i_item.read_line) < IMAGE_DIM) &&
                         (int'(i_item.read_byte_index) < BYTES_PER_LINE);
    assign rd_addr     = mem_addr(int'(i_item.read_line), int'(i_item.read_byte_index));

    // Settings and cell checks for a draw item
    always_comb begin
        span_w  = SPAN_W'(r_grid) * (SPAN_W'(r_cols) + SPAN_W'(2));
        span_h  = SPAN_W'(r_grid) * (SPAN_W'(r_rows) + SPAN_W'(2));
        set_ok  = (r_grid >= GRID_W'(2)) && (int'(r_grid) <= MAX_GRID) &&
                  (r_cols >= CELL_W'(1)) && (int'(r_cols) <= MAX_CELLS_PER_SIDE) &&
                  (r_rows >= CELL_W'(1)) && (int'(r_rows) <= MAX_CELLS_PER_SIDE) &&
                  (span_w <= SPAN_W'(IMAGE_DIM)) && (span_h <= SPAN_W'(IMAGE_DIM));
        cell_ok = (r_item.cell_col < r_cols) && (r_item.cell_row < r_rows);
        draw_ok = set_ok && cell_ok;
        x_full  = 10'(r_grid) * (10'(r_item.cell_col) + 10'd1);
        y_full  = 10'(r_grid) * (10'(r_item.cell_row) + 10'd1);
        walls_eff = '0;
        walls_eff[SEG_WEST]  = r_item.wall_west;
        walls_eff[SEG_NORTH] = r_item.wall_north;
        walls_eff[SEG_SOUTH] = r_item.wall_south &&
                               (r_item.cell_row == r_rows - CELL_W'(1));
        walls_eff[SEG_EAST]  = r_item.wall_east &&
                               (r_item.cell_col == r_cols - CELL_W'(1));
    end

    // Current segment: lowest pending wall
    always_comb begin
        if (r_walls[SEG_WEST]) begin
            seg = SEG_WEST;
        end else if (r_walls[SEG_NORTH]) begin
            seg = SEG_NORTH;
        end else if (r_walls[SEG_SOUTH]) begin
            seg = SEG_SOUTH;
        end else begin
            seg = SEG_EAST;
        end
        seg_vert   = (seg == SEG_WEST) || (seg == SEG_EAST);
        seg_last   = seg_vert ? (r_cnt == CNT_W'(r_grid)) : (r_cnt == CNT_W'(1));
        walls_left = r_walls & ~(4'b0001 << seg);
    end

    // Byte address and pixel mask of the current step
    always_comb begin
        px = r_x;
        py = r_y;
        case (seg)
            SEG_WEST: begin
                py = r_y + PIX_W'(r_cnt);
            end
            SEG_EAST: begin
                px = r_x + PIX_W'(r_grid);
                py = r_y + PIX_W'(r_cnt);
            end
            SEG_NORTH: begin
                py = r_y;
            end
            SEG_SOUTH: begin
                py = r_y + PIX_W'(r_grid);
            end
            default: begin
                py = r_y;
            end
        endcase
        // horizontal run of grid pixels spans at most two bytes
        hbyte   = r_x[PIX_W-1:3] + HBYTE_W'(r_cnt[0]);
        hmask16 = (16'hFFFF << (5'd16 - 5'(r_grid))) >> r_x[2:0];
        if (seg_vert) begin
            op_addr = mem_addr(int'(py), int'(px[PIX_W-1:3]));
            op_mask = 8'h80 >> px[2:0];
        end else begin
            op_addr = mem_addr(int'(py), int'(hbyte));
            op_mask = r_cnt[0] ? hmask16[7:0] : hmask16[15:8];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.func)
                        FUNC_CLEAR: n_state = ST_SWEEP;
                        FUNC_DRAW:  n_state = ST_SETUP;
                        FUNC_READ:  n_state = rd_in_range ? ST_FETCH : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP: begin
                n_state = (draw_ok && (walls_eff != 4'b0000)) ? ST_RMW_RD : ST_IDLE;
            end
            ST_RMW_RD: begin
                n_state = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                n_state = (seg_last && (walls_left == 4'b0000)) ? ST_IDLE : ST_RMW_RD;
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result
    always_comb begin
        n_item       = r_item;
        n_x          = r_x;
        n_y          = r_y;
        n_walls      = r_walls;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_mask       = r_mask;
        n_sweep      = r_sweep;
        n_from_clear = r_from_clear;
        n_strobe     = 1'b0;
        n_result     = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_addr;
        mem_raddr    = op_addr;
        mem_wdata    = r_q & ~r_mask;
        case (r_state)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = 8'hFF;
                n_sweep   = r_sweep + ADDR_W'(1);
                if (sweep_last && r_from_clear) begin
                    n_strobe        = 1'b1;
                    n_result.status = STAT_DONE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    case (i_item.func)
                        FUNC_CLEAR: begin
                            n_sweep      = '0;
                            n_from_clear = 1'b1;
                        end
                        FUNC_DRAW: begin
                        end
                        FUNC_READ: begin
                            if (rd_in_range) begin
                                mem_re    = 1'b1;
                                mem_raddr = rd_addr;
                            end else begin
                                n_strobe        = 1'b1;
                                n_result.status = STAT_REJECT;
                            end
                        end
                        default: begin
                            n_strobe        = 1'b1;
                            n_result.status = STAT_REJECT;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n_x     = PIX_W'(x_full);
                n_y     = PIX_W'(y_full);
                n_walls = walls_eff;
                n_cnt   = '0;
                if (!draw_ok) begin
                    n_strobe        = 1'b1;
                    n_result.status = STAT_REJECT;
                end else if (walls_eff == 4'b0000) begin
                    n_strobe        = 1'b1;
                    n_result.status = STAT_DONE;
                end
            end
            ST_RMW_RD: begin
                mem_re = 1'b1;
                n_addr = op_addr;
                n_mask = op_mask;
            end
            ST_RMW_WR: begin
                mem_we = 1'b1;
                if (seg_last) begin
                    n_cnt   = '0;
                    n_walls = walls_left;
                    if (walls_left == 4'b0000) begin
                        n_strobe        = 1'b1;
                        n_result.status = STAT_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FETCH: begin
                n_strobe           = 1'b1;
                n_result.read_data = r_q;
                n_result.status    = STAT_DONE;
            end
            default: begin
            end
        endcase
    end

    // Bitmap store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_q <= mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep      <= '0;
            r_from_clear <= 1'b0;
            r_walls      <= '0;
            r_cnt        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_from_clear <= n_from_clear;
            r_walls      <= n_walls;
            r_cnt        <= n_cnt;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_x      <= n_x;
        r_y      <= n_y;
        r_addr   <= n_addr;
        r_mask   <= n_mask;
        r_result <= n_result;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GRID_W'(2);
            r_cols <= CELL_W'(30);
            r_rows <= CELL_W'(30);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID: r_grid <= i_cfg_data[GRID_W-1:0];
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in the same cycle");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RMW_WR) |-> ($past(r_state) == ST_RMW_RD))
        else $error("modify-write without preceding read");

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while still busy");

    a_reject_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status) |-> (o_result.read_data == 8'h00))
        else $error("rejected item carries data");

    // a strobe right after another needs a new item taken at the first one's edge
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !accept) |=> !o_strobe)
        else $error("two results for one item");

endmodule
